// ===== design/tdl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_pkg
// shared types, constants and helpers of the threshold dilate block
// ----------------------------------------------------------------------------
package tdl_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W      = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int PIX_W      = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd185;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  localparam int RQ_DEPTH = 8;

  // up to three results caused by one pixel, in emission order
  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] white;
    logic [2:0] last;
  } tdl_bundle_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/threshold_dilate_5x5.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_dilate_5x5
// thresholds rgb pixels to foreground and applies a 5x5 binary dilation
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while in_tready is high. A pixel
// is read from the line store at acceptance and finished in the next cycle
// with its results pushed. Results of one pixel (up to three at a row end) go
// into an 8-entry queue and leave one per transfer; a row produces as many
// results as it has pixels, so the queue drains between row ends and input
// runs at one pixel per cycle while the output side keeps up. The line store
// is a MAX_WIDTH x 4 memory with one read and one write each cycle; it needs
// no clearing after reset because rows above the top edge are masked off.
// After frame_height real rows send two rows of pad items; tlast marks the
// last result of the frame. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module threshold_dilate_5x5 #(
  parameter int MAX_WIDTH  = tdl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tdl_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tdl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [tdl_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,   // red, green, blue
  input  wire logic                          in_tuser,   // opcode
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [7:0]                    out_tdata,  // white, zero fill
  output logic                               out_tlast   // frame_end
);
  import tdl_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 2);
  localparam int LW  = $clog2(RQ_DEPTH + 1);
  localparam int CMW = (WW > CW ? WW : CW) + 1;

  // configuration
  logic [WW-1:0]    width_r;
  logic [HW-1:0]    height_r;
  logic [PIX_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(clamp_dim(RST_FRAME_WIDTH, MAX_WIDTH));
      height_r <= HW'(clamp_dim(RST_FRAME_HEIGHT, MAX_HEIGHT));
      thr_r    <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  width_r  <= WW'(clamp_dim(cfg_wdata, MAX_WIDTH));
        REG_FRAME_HEIGHT: height_r <= HW'(clamp_dim(cfg_wdata, MAX_HEIGHT));
        REG_THRESHOLD:    thr_r    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // accept stage
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic          acc, row_end, frame_last, fg;
  logic [3:0]    mask;
  logic [PIX_W-1:0] red, green, blue;
  logic [LW:0]   occ;
  logic [LW-1:0] level;
  logic          s1_vld_r;

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  assign occ       = {1'b0, level} + (LW+1)'(s1_vld_r);
  assign in_tready = rst_n && (occ < (LW+1)'(RQ_DEPTH));
  assign acc       = in_tvalid && in_tready;

  assign row_end    = (CMW'(col_r) + CMW'(1)) >= CMW'(width_r);
  assign frame_last = row_end && ((HW+1)'(row_r) >= (HW+1)'(height_r) + (HW+1)'(1));
  assign fg = (in_tuser == OP_PIXEL) && (row_r < height_r) &&
              ((red > thr_r) || (green > thr_r) || (blue > thr_r));

  always_comb begin
    if (row_r >= HW'(4)) begin
      mask = 4'hF;
    end else begin
      case (row_r[1:0])
        2'd0:    mask = 4'h0;
        2'd1:    mask = 4'h1;
        2'd2:    mask = 4'h3;
        default: mask = 4'h7;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + HW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // finish stage
  logic [CW-1:0] s1_addr_r;
  logic          s1_fg_r, s1_row2_r, s1_c2_r, s1_c1_r, s1_rend_r, s1_flast_r;
  logic [3:0]    s1_mask_r;
  logic          fwd_r, fwd_nxt;
  logic [3:0]    fwd_data_r;
  logic [3:0]    cwin_r, cwin_nxt;
  logic [3:0]    rd_data, raw, hist, wr_data;
  logic          vcol;
  logic [4:0]    win;
  tdl_bundle_t   bnd;
  logic          push;

  // same column written by the finishing pixel while being read
  assign fwd_nxt = acc && s1_vld_r && (col_r == s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      cwin_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= acc;
      fwd_r    <= fwd_nxt;
      cwin_r   <= cwin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r  <= col_r;
      s1_fg_r    <= fg;
      s1_mask_r  <= mask;
      s1_row2_r  <= (row_r >= HW'(2));
      s1_c2_r    <= (col_r >= CW'(2));
      s1_c1_r    <= (col_r >= CW'(1));
      s1_rend_r  <= row_end;
      s1_flast_r <= frame_last;
      fwd_data_r <= wr_data;
    end
  end

  tdl_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  assign raw     = fwd_r ? fwd_data_r : rd_data;
  assign hist    = raw & s1_mask_r;
  assign vcol    = (hist != 4'h0) || s1_fg_r;
  assign wr_data = {hist[2:0], s1_fg_r};
  assign win     = {cwin_r, vcol};

  always_comb begin
    cwin_nxt = cwin_r;
    if (s1_vld_r) begin
      cwin_nxt = s1_rend_r ? 4'h0 : win[3:0];
    end
  end

  always_comb begin
    logic [1:0] k;
    k         = 2'd0;
    bnd.white = '0;
    bnd.last  = '0;
    if (s1_c2_r) begin
      bnd.white[k] = (win != 5'h00);
      bnd.last[k]  = s1_flast_r && !s1_rend_r;
      k            = k + 2'd1;
    end
    if (s1_rend_r && s1_c1_r) begin
      bnd.white[k] = (win[3:0] != 4'h0);
      bnd.last[k]  = 1'b0;
      k            = k + 2'd1;
    end
    if (s1_rend_r) begin
      bnd.white[k] = (win[2:0] != 3'h0);
      bnd.last[k]  = s1_flast_r;
      k            = k + 2'd1;
    end
    bnd.cnt = k;
  end

  assign push = s1_vld_r && s1_row2_r && (bnd.cnt != 2'd0);

  logic res_white;

  tdl_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bundle    (bnd),
    .level     (level),
    .res_valid (out_tvalid),
    .res_white (res_white),
    .res_last  (out_tlast),
    .res_ready (out_tready)
  );

  assign out_tdata = {7'b0, res_white};

  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_vld_r)
    else $error("forward without a finishing pixel");

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(in_tvalid && in_tready))
    else $error("finish stage valid without a transfer");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_addr_r == $past(s1_addr_r)))
    else $error("forward on a different column");

endmodule
`default_nettype wire

// ===== design/tdl_line_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_line_mem
// line store: four foreground bits per column, one write and one registered
// read per cycle, read returns the old contents on a same-address write
// ----------------------------------------------------------------------------
module tdl_line_mem #(
  parameter int DEPTH = tdl_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [3:0]               wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [3:0]               rd_data
);
  import tdl_pkg::*;

  logic [3:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/tdl_res_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_res_queue
// queue of result bundles, one bundle in per cycle, one result out per
// transfer
// ----------------------------------------------------------------------------
module tdl_res_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire tdl_pkg::tdl_bundle_t           bundle,
  output logic [$clog2(tdl_pkg::RQ_DEPTH+1)-1:0] level,
  output logic                                res_valid,
  output logic                                res_white,
  output logic                                res_last,
  input  wire logic                           res_ready
);
  import tdl_pkg::*;

  localparam int AW = $clog2(RQ_DEPTH);
  localparam int LW = $clog2(RQ_DEPTH+1);

  tdl_bundle_t    q_r [RQ_DEPTH];
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [LW-1:0]  count_r, count_nxt;
  logic [1:0]     sel_r, sel_nxt;
  tdl_bundle_t    hd;
  logic           xfer, pop;

  assign hd        = q_r[head_r];
  assign res_valid = (count_r != '0);
  assign res_white = hd.white[sel_r];
  assign res_last  = hd.last[sel_r];
  assign xfer      = res_valid && res_ready;
  assign pop       = xfer && (sel_r == hd.cnt - 2'd1);
  assign level     = count_r;

  always_comb begin
    head_nxt  = pop ? head_r + AW'(1) : head_r;
    tail_nxt  = push ? tail_r + AW'(1) : tail_r;
    count_nxt = count_r + LW'(push) - LW'(pop);
    sel_nxt   = pop ? 2'd0 : (xfer ? sel_r + 2'd1 : sel_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sel_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= bundle;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < LW'(RQ_DEPTH)))
    else $error("result queue overflow");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (bundle.cnt != 2'd0))
    else $error("empty bundle pushed");

  a_sel_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (sel_r < hd.cnt))
    else $error("result select past bundle end");

endmodule
`default_nettype wire
